// ===== hw/rtl/lcm_pkg.sv =====
package lcm_pkg;

  localparam int DimW    = 9;
  localparam int CoordW  = 8;
  localparam int KindW   = 2;
  localparam int CountW  = 7;
  localparam int CellW   = 8;
  localparam int CfgIdxW = 2;
  localparam int PcW     = 4;

  localparam logic [KindW-1:0] KIND_QUERY = 2'd0;
  localparam logic [KindW-1:0] KIND_SET   = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [CellW-1:0] LIVE_BIT   = 8'h01;
  localparam logic [CellW-1:0] COUNT_STEP = 8'h02;

  localparam logic [DimW-1:0] DIM_RESET = 9'd256;

  localparam logic [PcW-1:0] PC_START = 4'd0;
  localparam logic [PcW-1:0] PC_OUT   = 4'd9;
  localparam logic [PcW-1:0] PC_BAD   = 4'd10;

  typedef enum logic [1:0] {
    ACT_LIVE,
    ACT_BUMP,
    ACT_OUT,
    ACT_BAD
  } act_e;

  typedef enum logic [1:0] {
    ROW_UP,
    ROW_MID,
    ROW_DOWN
  } row_e;

  typedef enum logic [1:0] {
    COL_LEFT,
    COL_MID,
    COL_RIGHT
  } col_e;

  typedef enum logic {
    JMP_NONE,
    JMP_DISPATCH
  } jmp_e;

  typedef struct packed {
    act_e act;
    row_e row;
    col_e col;
    jmp_e jmp;
    logic last;
  } ucode_t;

  typedef struct packed {
    logic vld;
    act_e act;
    row_e row;
    col_e col;
    logic up;
  } issue_t;

  typedef struct packed {
    logic clr_busy;
    logic res_pend;
  } dp_status_t;

  typedef struct packed {
    logic              vld;
    logic              alive;
    logic [CountW-1:0] count;
    logic              bad;
  } result_t;

  // microprogram: center flag, eight neighbor bumps, center readout or out-of-grid result
  function automatic ucode_t fetch(input logic [PcW-1:0] pc);
    ucode_t uc;
    unique case (pc)
      PC_START: uc = '{ACT_LIVE, ROW_MID,  COL_MID,   JMP_DISPATCH, 1'b0};
      4'd1:     uc = '{ACT_BUMP, ROW_UP,   COL_LEFT,  JMP_NONE,     1'b0};
      4'd2:     uc = '{ACT_BUMP, ROW_UP,   COL_MID,   JMP_NONE,     1'b0};
      4'd3:     uc = '{ACT_BUMP, ROW_UP,   COL_RIGHT, JMP_NONE,     1'b0};
      4'd4:     uc = '{ACT_BUMP, ROW_MID,  COL_LEFT,  JMP_NONE,     1'b0};
      4'd5:     uc = '{ACT_BUMP, ROW_MID,  COL_RIGHT, JMP_NONE,     1'b0};
      4'd6:     uc = '{ACT_BUMP, ROW_DOWN, COL_LEFT,  JMP_NONE,     1'b0};
      4'd7:     uc = '{ACT_BUMP, ROW_DOWN, COL_MID,   JMP_NONE,     1'b0};
      4'd8:     uc = '{ACT_BUMP, ROW_DOWN, COL_RIGHT, JMP_NONE,     1'b0};
      PC_OUT:   uc = '{ACT_OUT,  ROW_MID,  COL_MID,   JMP_NONE,     1'b1};
      PC_BAD:   uc = '{ACT_BAD,  ROW_MID,  COL_MID,   JMP_NONE,     1'b1};
      default:  uc = '{ACT_BAD,  ROW_MID,  COL_MID,   JMP_NONE,     1'b1};
    endcase
    return uc;
  endfunction

endpackage

// ===== hw/rtl/toroidal_life_cell_map.sv =====
// set or clear: all ten microprogram steps run, center flag, eight neighbor bumps, readout
// query or out-of-grid coordinate: the start step dispatches straight to the result step,
// which waits while the previous result still occupies the output register or is in flight
// input stalls until the last step issues; each step but the bad one works on one cell
// reset: size registers to 256 by 256, then a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT
// cells (65536 by default) of the cell memory while input is stalled
module toroidal_life_cell_map #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lcm_pkg::DimW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lcm_pkg::KindW-1:0]     kind_i,
  input  logic [lcm_pkg::CoordW-1:0]    x_i,
  input  logic [lcm_pkg::CoordW-1:0]    y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          alive_o,
  output logic [lcm_pkg::CountW-1:0]    neighbor_count_o,
  output logic                          bad_coordinate_o
);

  localparam int DimW = lcm_pkg::DimW;

  logic [DimW-1:0]              width_q, height_q;
  logic [DimW-1:0]              w, h;
  logic [lcm_pkg::KindW-1:0]    kind_q;
  logic [lcm_pkg::CoordW-1:0]   x_q, y_q;
  logic                         bad_q;
  logic                         bad_now;
  logic                         accept;
  logic                         seq_busy;
  lcm_pkg::issue_t              issue;
  lcm_pkg::dp_status_t          dp_status;
  lcm_pkg::result_t             res;
  logic                         out_valid_q;
  logic                         alive_q, bad_out_q;
  logic [lcm_pkg::CountW-1:0]   count_q;

  always_comb begin
    if (width_q == '0) begin
      w = DimW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w = DimW'(MAX_WIDTH);
    end else begin
      w = width_q;
    end
    if (height_q == '0) begin
      h = DimW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h = DimW'(MAX_HEIGHT);
    end else begin
      h = height_q;
    end
    bad_now = ({1'b0, x_i} >= w) || ({1'b0, y_i} >= h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lcm_pkg::DIM_RESET;
      height_q <= lcm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcm_pkg::CFG_GRID_WIDTH:  width_q  <= cfg_wdata_i;
        lcm_pkg::CFG_GRID_HEIGHT: height_q <= cfg_wdata_i;
        default:                  width_q  <= width_q;
      endcase
    end
  end

  assign in_stall_o = dp_status.clr_busy || seq_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      x_q    <= x_i;
      y_q    <= y_i;
      bad_q  <= bad_now;
    end
  end

  lcm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .query_i   (!((kind_q == lcm_pkg::KIND_SET) || (kind_q == lcm_pkg::KIND_CLEAR))),
    .bad_i     (bad_q),
    .up_i      (kind_q == lcm_pkg::KIND_SET),
    .blocked_i (out_valid_q || dp_status.res_pend),
    .busy_o    (seq_busy),
    .issue_o   (issue)
  );

  lcm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .x_i      (x_q),
    .y_i      (y_q),
    .w_i      (w),
    .h_i      (h),
    .status_o (dp_status),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.vld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      alive_q   <= res.alive;
      count_q   <= res.count;
      bad_out_q <= res.bad;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign alive_o          = alive_q;
  assign neighbor_count_o = count_q;
  assign bad_coordinate_o = bad_out_q;

  // no result may land on a transfer still waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a pending output transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.clr_busy |-> (!seq_busy && !issue.vld))
    else $error("microprogram ran during memory clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_coordinate_o) |-> (!alive_o && (neighbor_count_o == '0)))
    else $error("out-of-grid result carries cell data");

endmodule

// ===== hw/rtl/lcm_seq.sv =====
module lcm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            query_i,
  input  logic            bad_i,
  input  logic            up_i,
  input  logic            blocked_i,
  output logic            busy_o,
  output lcm_pkg::issue_t issue_o
);

  localparam int PcW = lcm_pkg::PcW;

  logic                busy_q, busy_d;
  logic [PcW-1:0]      pc_q, pc_d;
  lcm_pkg::ucode_t     uc;
  logic                hold;
  logic                taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= lcm_pkg::PC_START;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_comb begin
    uc    = lcm_pkg::fetch(pc_q);
    // result steps wait until the output slot is free
    hold  = ((uc.act == lcm_pkg::ACT_OUT) || (uc.act == lcm_pkg::ACT_BAD)) && blocked_i;
    taken = (uc.jmp == lcm_pkg::JMP_DISPATCH) && (bad_i || query_i);
    busy_d = busy_q;
    pc_d   = pc_q;
    issue_o = '{vld: 1'b0, act: uc.act, row: uc.row, col: uc.col, up: up_i};
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = lcm_pkg::PC_START;
      end
    end else if (hold) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = bad_i ? lcm_pkg::PC_BAD : lcm_pkg::PC_OUT;
    end else begin
      issue_o.vld = 1'b1;
      if (uc.last) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== hw/rtl/lcm_dp.sv =====
module lcm_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcm_pkg::issue_t              issue_i,
  input  logic [lcm_pkg::CoordW-1:0]   x_i,
  input  logic [lcm_pkg::CoordW-1:0]   y_i,
  input  logic [lcm_pkg::DimW-1:0]     w_i,
  input  logic [lcm_pkg::DimW-1:0]     h_i,
  output lcm_pkg::dp_status_t          status_o,
  output lcm_pkg::result_t             res_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);
  localparam int DimW  = lcm_pkg::DimW;
  localparam int ProdW = 2 * DimW;
  localparam int SumW  = ProdW + 1;
  localparam int CellW = lcm_pkg::CellW;

  logic [CellW-1:0] mem [Depth];

  logic [DimW-1:0]  x9, y9, col_sel, row_sel;
  logic [ProdW-1:0] prod;
  logic [SumW-1:0]  sum;
  logic [AddrW-1:0] addr_d;

  logic             s1_vld_q;
  lcm_pkg::act_e    s1_act_q;
  logic             s1_up_q;
  logic [AddrW-1:0] s1_addr_q;

  logic             s2_vld_q;
  lcm_pkg::act_e    s2_act_q;
  logic             s2_up_q;
  logic [AddrW-1:0] s2_addr_q;
  logic [CellW-1:0] rdata_q;

  logic             fwd_vld_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [CellW-1:0] fwd_data_q;

  logic             clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;

  logic [CellW-1:0] cur, upd;
  logic             s2_wr;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [CellW-1:0] mem_wdata;

  // wrapped neighbor coordinates and linear address
  always_comb begin
    x9 = {1'b0, x_i};
    y9 = {1'b0, y_i};
    case (issue_i.col)
      lcm_pkg::COL_LEFT:  col_sel = (x9 == '0) ? w_i - 1'b1 : x9 - 1'b1;
      lcm_pkg::COL_RIGHT: col_sel = (x9 == w_i - 1'b1) ? '0 : x9 + 1'b1;
      default:            col_sel = x9;
    endcase
    case (issue_i.row)
      lcm_pkg::ROW_UP:   row_sel = (y9 == '0) ? h_i - 1'b1 : y9 - 1'b1;
      lcm_pkg::ROW_DOWN: row_sel = (y9 == h_i - 1'b1) ? '0 : y9 + 1'b1;
      default:           row_sel = y9;
    endcase
    prod   = ProdW'(row_sel) * ProdW'(w_i);
    sum    = SumW'(prod) + SumW'(col_sel);
    addr_d = AddrW'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      s1_vld_q  <= issue_i.vld;
      s2_vld_q  <= s1_vld_q;
      fwd_vld_q <= s2_wr;
      if (clr_busy_q) begin
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.vld) begin
      s1_act_q  <= issue_i.act;
      s1_up_q   <= issue_i.up;
      s1_addr_q <= addr_d;
    end
    if (s1_vld_q) begin
      s2_act_q  <= s1_act_q;
      s2_up_q   <= s1_up_q;
      s2_addr_q <= s1_addr_q;
    end
    if (s2_wr) begin
      fwd_addr_q <= s2_addr_q;
      fwd_data_q <= upd;
    end
  end

  always_comb begin
    // the write of the previous step is not yet visible to this read
    cur = (fwd_vld_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : rdata_q;
    case (s2_act_q)
      lcm_pkg::ACT_LIVE: upd = s2_up_q ? (cur | lcm_pkg::LIVE_BIT)
                                       : (cur & ~lcm_pkg::LIVE_BIT);
      lcm_pkg::ACT_BUMP: upd = s2_up_q ? (cur + lcm_pkg::COUNT_STEP)
                                       : (cur - lcm_pkg::COUNT_STEP);
      default:           upd = cur;
    endcase
    s2_wr = s2_vld_q && ((s2_act_q == lcm_pkg::ACT_LIVE) || (s2_act_q == lcm_pkg::ACT_BUMP));
    mem_we    = clr_busy_q || s2_wr;
    mem_waddr = clr_busy_q ? clr_cnt_q : s2_addr_q;
    mem_wdata = clr_busy_q ? '0 : upd;
    mem_re    = s1_vld_q && (s1_act_q != lcm_pkg::ACT_BAD);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[s1_addr_q];
    end
  end

  always_comb begin
    res_o.vld   = s2_vld_q &&
                  ((s2_act_q == lcm_pkg::ACT_OUT) || (s2_act_q == lcm_pkg::ACT_BAD));
    res_o.alive = (s2_act_q == lcm_pkg::ACT_OUT) && cur[0];
    res_o.count = (s2_act_q == lcm_pkg::ACT_OUT) ? cur[CellW-1:1] : '0;
    res_o.bad   = (s2_act_q == lcm_pkg::ACT_BAD);
    status_o.clr_busy = clr_busy_q;
    status_o.res_pend =
      (s1_vld_q && ((s1_act_q == lcm_pkg::ACT_OUT) || (s1_act_q == lcm_pkg::ACT_BAD))) ||
      (s2_vld_q && ((s2_act_q == lcm_pkg::ACT_OUT) || (s2_act_q == lcm_pkg::ACT_BAD)));
  end

endmodule
